[hdl/priority_trigger_arbiter_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the priority trigger arbiter
// Shared wrappers so that every concurrent check is clocked the same way.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_TRIGGER_ARBITER_DEFINES_SVH
`define PRIORITY_TRIGGER_ARBITER_DEFINES_SVH

// Check sampled on the rising edge of clk, also during reset
`define PTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check sampled on the rising edge of clk, switched off while in reset
`define PTA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[hdl/pta_pkg.sv]
// ---------------------------------------------------------------------------
// pta_pkg
// Sizes, codes and the scan word shared by the arbiter and its cells.
// ---------------------------------------------------------------------------
package pta_pkg;

  // Geometry
  localparam int NUM_TRIGGERS = 8;
  localparam int TYPE_BITS    = 2;
  localparam int PRIO_W       = 2;
  localparam int IDX_W        = $clog2(NUM_TRIGGERS);
  localparam int CNT_W        = 4;
  localparam int CMP_W        = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam int PRIO_TBL_W   = PRIO_W * NUM_TRIGGERS;
  localparam int TYPE_TBL_W   = TYPE_BITS * NUM_TRIGGERS;
  localparam int CFG_DATA_W   = (PRIO_TBL_W > TYPE_TBL_W) ?
                                ((PRIO_TBL_W > NUM_TRIGGERS) ? PRIO_TBL_W : NUM_TRIGGERS) :
                                ((TYPE_TBL_W > NUM_TRIGGERS) ? TYPE_TBL_W : NUM_TRIGGERS);
  localparam int CFG_IDX_W    = 2;
  localparam int KIND_W       = 2;
  localparam int EV_W         = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR = 2'd3;

  // Event carried by the scan word
  localparam logic [EV_W-1:0] EV_NONE = 2'd0;
  localparam logic [EV_W-1:0] EV_RISE = 2'd1;
  localparam logic [EV_W-1:0] EV_FALL = 2'd2;

  // Action codes
  localparam logic [KIND_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] ACT_OWN   = 2'd1;
  localparam logic [KIND_W-1:0] ACT_SAME  = 2'd2;
  localparam logic [KIND_W-1:0] ACT_DEACT = 2'd3;

  // Word handed from cell to cell during a scan
  typedef struct packed {
    logic                 vld;
    logic [IDX_W-1:0]     pos;
    logic [EV_W-1:0]      ev;
    logic [IDX_W-1:0]     idx;
    logic                 panel;
    logic [PRIO_W-1:0]    ref_prio;
    logic [TYPE_BITS-1:0] ref_type;
    logic                 blocked;
    logic                 found;
    logic [IDX_W-1:0]     best;
    logic [PRIO_W-1:0]    best_prio;
    logic                 any;
  } scan_t;

endpackage

[hdl/pta_cell.sv]
// ---------------------------------------------------------------------------
// pta_cell
// One trigger slot: holds the active flag and folds itself into the passing
// scan word, which it registers on to the next cell.
// ---------------------------------------------------------------------------
module pta_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             upd,
  input  logic                             upd_val,
  input  logic                             in_range,
  input  logic [pta_pkg::PRIO_W-1:0]       prio,
  input  logic [pta_pkg::TYPE_BITS-1:0]    trig_type,
  input  pta_pkg::scan_t                   scan_in,
  output pta_pkg::scan_t                   scan_out,
  output logic                             flag
);
  import pta_pkg::*;

  logic  flag_r, flag_nxt;
  scan_t scan_r, scan_nxt;
  logic  act;

  // Active flag
  assign flag_nxt = upd ? upd_val : flag_r;
  assign act      = flag_r & in_range;

  // Fold this slot into the scan word
  always_comb begin
    scan_nxt     = scan_in;
    scan_nxt.pos = scan_in.pos + IDX_W'(1);
    if (scan_in.vld) begin
      scan_nxt.any = scan_in.any | act;
      if (scan_in.ev == EV_RISE && act && prio > scan_in.ref_prio) begin
        scan_nxt.blocked = 1'b1;
      end
      if (scan_in.ev == EV_FALL && act && trig_type == scan_in.ref_type &&
          (!scan_in.found || prio > scan_in.best_prio)) begin
        scan_nxt.found     = 1'b1;
        scan_nxt.best      = scan_in.pos;
        scan_nxt.best_prio = prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
      scan_r <= '0;
    end else begin
      flag_r <= flag_nxt;
      scan_r <= scan_nxt;
    end
  end

  assign scan_out = scan_r;
  assign flag     = flag_r;

endmodule

[hdl/priority_trigger_arbiter.sv]
// ---------------------------------------------------------------------------
// priority_trigger_arbiter
// Tracks active triggers and picks the action for each sensor change word.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  in      | start / busy         | in_trigger_index, in_sensor_level,
//          |                      | in_error_panel_up
//  out     | out_valid (strobe)   | out_action_kind, out_action_trigger,
//          |                      | out_any_active
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// A word is taken when start is high and busy low; its flag update lands at
// that edge. The scan word then walks the row of NUM_TRIGGERS cells, one cell
// per cycle; the result strobes once the scan word leaves the last cell.
// busy drops with the strobe, so no new word is taken until the result is out.
// Synchronous active-low reset clears flags and control/config registers but
// not the payload. The strobe is one cycle wide; the receiver cannot stall it.
// ---------------------------------------------------------------------------
`include "priority_trigger_arbiter_defines.svh"

module priority_trigger_arbiter (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               start,
  output logic                               busy,
  input  logic [pta_pkg::IDX_W-1:0]          in_trigger_index,
  input  logic                               in_sensor_level,
  input  logic                               in_error_panel_up,
  // result channel
  output logic                               out_valid,
  output logic [pta_pkg::KIND_W-1:0]         out_action_kind,
  output logic [pta_pkg::IDX_W-1:0]          out_action_trigger,
  output logic                               out_any_active,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pta_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pta_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import pta_pkg::*;

  logic [CNT_W-1:0]        count_r;
  logic [PRIO_TBL_W-1:0]   prio_tbl_r;
  logic [TYPE_TBL_W-1:0]   type_tbl_r;
  logic [NUM_TRIGGERS-1:0] sensor_r;

  logic                    busy_r, busy_nxt;
  logic                    out_valid_r;
  logic [KIND_W-1:0]       out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]        out_trig_r, out_trig_nxt;
  logic                    out_any_r;

  logic [CMP_W-1:0]        cnt_ext, eff_n;
  logic [NUM_TRIGGERS-1:0] flags;
  logic [NUM_TRIGGERS-1:0] upd;
  logic                    accept, idx_ok, was;
  logic [EV_W-1:0]         ev;
  scan_t                   head_r, head_nxt;
  scan_t                   chain [NUM_TRIGGERS+1];
  scan_t                   tail;

  // Configuration registers, written only while idle with no word offered
  assign cfg_ready = ~busy_r & ~start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      prio_tbl_r <= '0;
      type_tbl_r <= '0;
      sensor_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COUNT:  count_r    <= cfg_wdata[CNT_W-1:0];
        REG_PRIO:   prio_tbl_r <= cfg_wdata[PRIO_TBL_W-1:0];
        REG_TYPE:   type_tbl_r <= cfg_wdata[TYPE_TBL_W-1:0];
        REG_SENSOR: sensor_r   <= cfg_wdata[NUM_TRIGGERS-1:0];
        default: ;
      endcase
    end
  end

  // Effective count, clamped to the number of slots
  assign cnt_ext = CMP_W'(count_r);
  assign eff_n   = (cnt_ext > CMP_W'(NUM_TRIGGERS)) ? CMP_W'(NUM_TRIGGERS) : cnt_ext;

  // Event decode at acceptance
  assign accept = start & ~busy_r;
  assign idx_ok = (CMP_W'(in_trigger_index) < eff_n) & sensor_r[in_trigger_index];
  assign was    = flags[in_trigger_index];

  always_comb begin
    ev = EV_NONE;
    if (idx_ok) begin
      if (!was && in_sensor_level) begin
        ev = EV_RISE;
      end else if (was && !in_sensor_level) begin
        ev = EV_FALL;
      end
    end
  end

  // Flag write strobe per cell
  always_comb begin
    for (int i = 0; i < NUM_TRIGGERS; i++) begin
      upd[i] = accept && ev != EV_NONE && in_trigger_index == IDX_W'(i);
    end
  end

  // Scan word launched into the row
  always_comb begin
    head_nxt          = '0;
    head_nxt.vld      = accept;
    head_nxt.ev       = ev;
    head_nxt.idx      = in_trigger_index;
    head_nxt.panel    = in_error_panel_up;
    head_nxt.ref_prio = prio_tbl_r[in_trigger_index*PRIO_W +: PRIO_W];
    head_nxt.ref_type = type_tbl_r[in_trigger_index*TYPE_BITS +: TYPE_BITS];
  end

  assign chain[0] = head_r;

  // Row of cells
  for (genvar g = 0; g < NUM_TRIGGERS; g++) begin : g_cell
    pta_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .upd       (upd[g]),
      .upd_val   (in_sensor_level),
      .in_range  (CMP_W'(g) < eff_n),
      .prio      (prio_tbl_r[g*PRIO_W +: PRIO_W]),
      .trig_type (type_tbl_r[g*TYPE_BITS +: TYPE_BITS]),
      .scan_in   (chain[g]),
      .scan_out  (chain[g+1]),
      .flag      (flags[g])
    );
  end

  assign tail = chain[NUM_TRIGGERS];

  // Result formatting
  always_comb begin
    out_kind_nxt = ACT_NONE;
    out_trig_nxt = '0;
    case (tail.ev)
      EV_RISE: begin
        if (!tail.blocked && !tail.panel) begin
          out_kind_nxt = ACT_OWN;
          out_trig_nxt = tail.idx;
        end
      end
      EV_FALL: begin
        if (tail.found) begin
          out_kind_nxt = ACT_SAME;
          out_trig_nxt = tail.best;
        end else begin
          out_kind_nxt = ACT_DEACT;
          out_trig_nxt = tail.idx;
        end
      end
      default: ;
    endcase
  end

  // Busy spans launch to result strobe
  assign busy_nxt = accept ? 1'b1 : (tail.vld ? 1'b0 : busy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= tail.vld;
      head_r      <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      out_kind_r <= out_kind_nxt;
      out_trig_r <= out_trig_nxt;
      out_any_r  <= tail.any;
    end
  end

  assign busy               = busy_r;
  assign out_valid          = out_valid_r;
  assign out_action_kind    = out_kind_r;
  assign out_action_trigger = out_trig_r;
  assign out_any_active     = out_any_r;

  // Checks
  `PTA_ASSERT_RST(a_accept_sets_busy, accept |=> busy_r, "busy not raised after accept")
  `PTA_ASSERT_RST(a_strobe_idle, out_valid_r |-> !busy_r, "result strobe while still busy")
  `PTA_ASSERT_RST(a_single_strobe, out_valid_r |=> !out_valid_r, "result strobe repeated")
  `PTA_ASSERT_RST(a_none_zero, (out_valid_r && out_kind_r == ACT_NONE) |-> out_trig_r == '0,
                  "no-action result carries a trigger index")
  `PTA_ASSERT(a_reset_idle, !rst_n |=> !busy_r && !out_valid_r, "not idle after reset")

endmodule
